### design/gda_pkg.sv
// shared types, constants and calendar helpers for the date adder
// no dependencies; imported by gda_ctrl, gda_dp and gregorian_date_add_days
package gda_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [YEAR_W-1:0] YEAR_MIN     = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd9999;
  localparam logic [YEAR_W-1:0] DEFAULT_YEAR = 14'd1900;
  localparam logic [YEAR_W-1:0] CYCLE_YEARS  = 14'd400;
  localparam logic [YEAR_W-1:0] CYCLE_LAST   = 14'd399;
  localparam logic [YEAR_W-1:0] CENTURY_1    = 14'd100;
  localparam logic [YEAR_W-1:0] CENTURY_2    = 14'd200;
  localparam logic [YEAR_W-1:0] CENTURY_3    = 14'd300;
  // 1900 mod 400
  localparam logic [YEAR_W-1:0] DEFAULT_REM  = 14'd300;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LAST  = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_FWD,
    ST_BWD,
    ST_DONE
  } gda_state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic fwd;
    logic bwd;
  } gda_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic fwd_more;
    logic bwd_more;
  } gda_status_t;

  // leap test from year mod 400
  function automatic logic leap_from_rem(input logic [YEAR_W-1:0] r);
    leap_from_rem = (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) &&
                    (r != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic lp);
    case (m) inside
      MON_FEB:                       month_len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:       month_len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, MON_DEC:                month_len = 5'd31;
      default:                       month_len = 5'd0;
    endcase
  endfunction

endpackage

### design/gregorian_date_add_days.sv
// date adder top level: gda_ctrl state machine plus gda_dp datapath
// depends on gda_pkg, gda_ctrl, gda_dp
// the year is first reduced mod 400 by repeated subtraction, then the day offset is
//   added and the month stepping loop walks forward and then backward to the result
// the month stepping loop moves one month per cycle
// one item at a time: busy stays high until the result strobe has gone out
// out_valid is a one-cycle strobe, the receiver cannot stall
// synchronous active-low reset returns the controller to idle, no result pending
module gregorian_date_add_days #(
  parameter int OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [gda_pkg::YEAR_W-1:0]     in_base_year,
  input  logic [gda_pkg::MONTH_W-1:0]    in_base_month,
  input  logic [gda_pkg::DAY_W-1:0]      in_base_day,
  input  logic signed [OFFSET_BITS-1:0]  in_day_offset,
  output logic                           out_valid,
  output logic [gda_pkg::YEAR_W-1:0]     out_result_year,
  output logic [gda_pkg::MONTH_W-1:0]    out_result_month,
  output logic [gda_pkg::DAY_W-1:0]      out_result_day,
  output logic                           out_base_was_invalid,
  output logic                           out_year_overflow
);
  import gda_pkg::*;

  gda_cmd_t    cmd;
  gda_status_t status;

  gda_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  gda_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .status               (status),
    .in_base_year         (in_base_year),
    .in_base_month        (in_base_month),
    .in_base_day          (in_base_day),
    .in_day_offset        (in_day_offset),
    .out_result_year      (out_result_year),
    .out_result_month     (out_result_month),
    .out_result_day       (out_result_day),
    .out_base_was_invalid (out_base_was_invalid),
    .out_year_overflow    (out_year_overflow)
  );

  // strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  // result month always legal
  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_month >= MON_JAN) && (out_result_month <= MON_DEC))
    else $error("result month out of range");

  // overflow saturates to one of the calendar limits
  a_ovf_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_overflow) |->
      ((out_result_year == YEAR_MAX) && (out_result_month == MON_DEC) &&
       (out_result_day == DAY_LAST)) ||
      ((out_result_year == YEAR_MIN) && (out_result_month == MON_JAN) &&
       (out_result_day == DAY_FIRST)))
    else $error("overflowed result not saturated");

endmodule

### design/gda_ctrl.sv
// sequencing state machine for the date adder
// depends on gda_pkg; drives commands into gda_dp from its status
module gda_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gda_pkg::gda_status_t status,
  output gda_pkg::gda_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import gda_pkg::*;

  gda_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_REDUCE;
      ST_REDUCE: if (status.mod_done) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ST_FWD;
      ST_FWD:    if (!status.fwd_more) state_nxt = ST_BWD;
      ST_BWD:    if (!status.bwd_more) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_CHECK:  cmd.check  = 1'b1;
      ST_FWD:    cmd.fwd    = 1'b1;
      ST_BWD:    cmd.bwd    = 1'b1;
      ST_DONE:   done       = 1'b1;
      default:   busy       = 1'b1;
    endcase
  end

endmodule

### design/gda_dp.sv
// date registers, year mod 400 tracking and month stepping for the date adder
// depends on gda_pkg; commanded by gda_ctrl
module gda_dp #(
  parameter int OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  gda_pkg::gda_cmd_t                  cmd,
  output gda_pkg::gda_status_t               status,
  input  logic [gda_pkg::YEAR_W-1:0]         in_base_year,
  input  logic [gda_pkg::MONTH_W-1:0]        in_base_month,
  input  logic [gda_pkg::DAY_W-1:0]          in_base_day,
  input  logic signed [OFFSET_BITS-1:0]      in_day_offset,
  output logic [gda_pkg::YEAR_W-1:0]         out_result_year,
  output logic [gda_pkg::MONTH_W-1:0]        out_result_month,
  output logic [gda_pkg::DAY_W-1:0]          out_result_day,
  output logic                               out_base_was_invalid,
  output logic                               out_year_overflow
);
  import gda_pkg::*;

  localparam int DW = OFFSET_BITS + 7;

  logic [YEAR_W-1:0]        year_r, year_nxt;
  logic [YEAR_W-1:0]        rem_r, rem_nxt;
  logic [MONTH_W-1:0]       month_r, month_nxt;
  logic signed [DW-1:0]     day_r, day_nxt;
  logic signed [OFFSET_BITS-1:0] off_r, off_nxt;
  logic                     invalid_r, invalid_nxt;
  logic                     ovf_r, ovf_nxt;

  logic                     leap_cur;
  logic [DAY_W-1:0]         mlen_cur;
  logic [DAY_W-1:0]         mlen_prev;
  logic signed [DW-1:0]     mlen_cur_x;
  logic signed [DW-1:0]     mlen_prev_x;
  logic signed [DW-1:0]     off_x;
  logic                     base_ok;

  always_ff @(posedge clk) begin
    year_r    <= year_nxt;
    rem_r     <= rem_nxt;
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    off_r     <= off_nxt;
    invalid_r <= invalid_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign leap_cur    = leap_from_rem(rem_r);
  assign mlen_cur    = month_len(month_r, leap_cur);
  assign mlen_prev   = month_len(month_r - MON_JAN, leap_cur);
  assign mlen_cur_x  = $signed({{(DW-DAY_W){1'b0}}, mlen_cur});
  assign mlen_prev_x = $signed({{(DW-DAY_W){1'b0}}, mlen_prev});
  assign off_x       = $signed({{(DW-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r});

  assign base_ok = (year_r >= YEAR_MIN) && (year_r <= YEAR_MAX) &&
                   (month_r >= MON_JAN) && (month_r <= MON_DEC) &&
                   (day_r != '0) && (day_r <= mlen_cur_x);

  assign status.mod_done = (rem_r < CYCLE_YEARS);
  assign status.fwd_more = !ovf_r && (day_r > mlen_cur_x);
  assign status.bwd_more = !ovf_r && (day_r <= $signed({DW{1'b0}}));

  always_comb begin
    year_nxt    = year_r;
    rem_nxt     = rem_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    off_nxt     = off_r;
    invalid_nxt = invalid_r;
    ovf_nxt     = ovf_r;

    if (cmd.load) begin
      year_nxt    = in_base_year;
      rem_nxt     = in_base_year;
      month_nxt   = in_base_month;
      day_nxt     = $signed({{(DW-DAY_W){1'b0}}, in_base_day});
      off_nxt     = in_day_offset;
      invalid_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end else if (cmd.reduce) begin
      if (!status.mod_done) rem_nxt = rem_r - CYCLE_YEARS;
    end else if (cmd.check) begin
      if (base_ok) begin
        day_nxt = day_r + off_x;
      end else begin
        invalid_nxt = 1'b1;
        year_nxt    = DEFAULT_YEAR;
        rem_nxt     = DEFAULT_REM;
        month_nxt   = MON_JAN;
        day_nxt     = $signed({{(DW-DAY_W){1'b0}}, DAY_FIRST}) + off_x;
      end
    end else if (cmd.fwd && status.fwd_more) begin
      day_nxt = day_r - mlen_cur_x;
      if (month_r == MON_DEC) begin
        if (year_r == YEAR_MAX) begin
          ovf_nxt   = 1'b1;
          month_nxt = MON_DEC;
          day_nxt   = $signed({{(DW-DAY_W){1'b0}}, DAY_LAST});
        end else begin
          year_nxt  = year_r + 14'd1;
          month_nxt = MON_JAN;
          rem_nxt   = (rem_r == CYCLE_LAST) ? '0 : rem_r + 14'd1;
        end
      end else begin
        month_nxt = month_r + 4'd1;
      end
    end else if (cmd.bwd && status.bwd_more) begin
      if (month_r == MON_JAN) begin
        if (year_r == YEAR_MIN) begin
          ovf_nxt   = 1'b1;
          month_nxt = MON_JAN;
          day_nxt   = $signed({{(DW-DAY_W){1'b0}}, DAY_FIRST});
        end else begin
          year_nxt  = year_r - 14'd1;
          month_nxt = MON_DEC;
          rem_nxt   = (rem_r == '0) ? CYCLE_LAST : rem_r - 14'd1;
          day_nxt   = day_r + $signed({{(DW-DAY_W){1'b0}}, DAY_LAST});
        end
      end else begin
        month_nxt = month_r - 4'd1;
        day_nxt   = day_r + mlen_prev_x;
      end
    end
  end

  assign out_result_year      = year_r;
  assign out_result_month     = month_r;
  assign out_result_day       = day_r[DAY_W-1:0];
  assign out_base_was_invalid = invalid_r;
  assign out_year_overflow    = ovf_r;

endmodule
